// ===== design/lmts_pkg.sv =====
// ----------------------------------------------------------------------------
// lmts_pkg: shared types and constants for the lcd mode timing sequencer
// word layouts, mode codes and the per-mode cycle budgets
// ----------------------------------------------------------------------------
`default_nettype none

package lmts_pkg;

    localparam int CLOCK_W = 11;

    // mode codes
    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_DRAW   = 2'd3;

    // cycle budget of each mode
    localparam logic [CLOCK_W-1:0] OAM_CYCLES         = 11'd80;
    localparam logic [CLOCK_W-1:0] DRAW_CYCLES        = 11'd172;
    localparam logic [CLOCK_W-1:0] HBLANK_CYCLES      = 11'd204;
    localparam logic [CLOCK_W-1:0] VBLANK_LINE_CYCLES = 11'd456;
    localparam logic [CLOCK_W-1:0] CLOCK_MAX          = 11'h7FF;

    localparam logic [7:0] VISIBLE_LINES = 8'd144;
    localparam logic [7:0] LAST_LINE     = 8'd153;
    localparam logic [7:0] WIN_X_LIMIT   = 8'd167;

    typedef struct packed {
        logic [7:0] cycles;
        logic       lcd_on;
        logic       bg_win_on;
        logic       window_on;
        logic [7:0] window_y;
        logic [7:0] window_x;
        logic       hblank_irq_en;
        logic       vblank_irq_en;
        logic       oam_irq_en;
    } lmts_word_t;

    typedef struct packed {
        logic [CLOCK_W-1:0] dot_count;
        logic [1:0]         cur_mode;
        logic [7:0]         line_count;
        logic [7:0]         win_line_count;
        logic               win_active;
        logic               lcd_was_on;
    } lmts_state_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] line;
        logic [7:0] window_line;
        logic       render_line;
        logic       vblank_irq;
        logic       stat_irq;
        logic       lyc_check;
        logic       frame_ready;
        logic       screen_clear;
    } lmts_result_t;

endpackage

`default_nettype wire

// ===== design/lmts_step.sv =====
// ----------------------------------------------------------------------------
// lmts_step: next-state and event logic for one step word
// adds the elapsed cycles and makes at most one mode move
// ----------------------------------------------------------------------------
`default_nettype none

module lmts_step (
    input  wire lmts_pkg::lmts_word_t   word,
    input  wire lmts_pkg::lmts_state_t  cur,
    output lmts_pkg::lmts_state_t       nxt,
    output lmts_pkg::lmts_result_t      res
);
    import lmts_pkg::*;

    logic [CLOCK_W:0]   clk_sum;
    logic [CLOCK_W-1:0] clk_sat;
    logic [1:0]         mode_in;
    logic [7:0]         line_inc;

    assign clk_sum  = {1'b0, cur.dot_count} + {{(CLOCK_W-7){1'b0}}, word.cycles};
    assign clk_sat  = clk_sum[CLOCK_W] ? CLOCK_MAX : clk_sum[CLOCK_W-1:0];
    assign mode_in  = cur.lcd_was_on ? cur.cur_mode : MODE_OAM;
    assign line_inc = cur.line_count + 8'd1;

    always_comb
    begin
        nxt              = cur;
        res.render_line  = 1'b0;
        res.vblank_irq   = 1'b0;
        res.stat_irq     = 1'b0;
        res.lyc_check    = 1'b0;
        res.frame_ready  = 1'b0;
        res.screen_clear = 1'b0;

        if (!word.lcd_on)
        begin
            if (cur.lcd_was_on)
            begin
                nxt.dot_count      = '0;
                nxt.cur_mode       = MODE_HBLANK;
                nxt.line_count     = '0;
                nxt.win_line_count = '0;
                nxt.win_active     = 1'b0;
                res.screen_clear   = 1'b1;
            end
            nxt.lcd_was_on = 1'b0;
        end
        else
        begin
            res.lyc_check  = !cur.lcd_was_on;
            nxt.lcd_was_on = 1'b1;
            nxt.cur_mode   = mode_in;
            nxt.dot_count  = clk_sat;
            unique case (mode_in)
                MODE_OAM:
                begin
                    if (clk_sat >= OAM_CYCLES)
                    begin
                        if (cur.line_count == word.window_y)
                            nxt.win_active = 1'b1;
                        nxt.cur_mode  = MODE_DRAW;
                        nxt.dot_count = clk_sat - OAM_CYCLES;
                    end
                end
                MODE_DRAW:
                begin
                    if (clk_sat >= DRAW_CYCLES)
                    begin
                        nxt.cur_mode    = MODE_HBLANK;
                        res.render_line = 1'b1;
                        if (word.bg_win_on && word.window_on && cur.win_active
                            && (word.window_x < WIN_X_LIMIT))
                            nxt.win_line_count = cur.win_line_count + 8'd1;
                        nxt.dot_count   = clk_sat - DRAW_CYCLES;
                        res.stat_irq    = word.hblank_irq_en;
                    end
                end
                MODE_HBLANK:
                begin
                    if (clk_sat >= HBLANK_CYCLES)
                    begin
                        nxt.line_count = line_inc;
                        if (line_inc == VISIBLE_LINES)
                        begin
                            res.frame_ready = 1'b1;
                            res.vblank_irq  = 1'b1;
                            nxt.cur_mode    = MODE_VBLANK;
                            res.stat_irq    = word.vblank_irq_en;
                        end
                        else
                        begin
                            nxt.cur_mode = MODE_OAM;
                            res.stat_irq = word.oam_irq_en;
                        end
                        nxt.dot_count = clk_sat - HBLANK_CYCLES;
                    end
                end
                MODE_VBLANK:
                begin
                    if (clk_sat >= VBLANK_LINE_CYCLES)
                    begin
                        nxt.line_count = line_inc;
                        if (line_inc > LAST_LINE)
                        begin
                            // end of frame, restart in oam scan
                            nxt.line_count     = '0;
                            nxt.win_line_count = '0;
                            nxt.win_active     = 1'b0;
                            nxt.cur_mode       = MODE_OAM;
                        end
                        nxt.dot_count = clk_sat - VBLANK_LINE_CYCLES;
                    end
                end
            endcase
        end

        res.mode        = nxt.cur_mode;
        res.line        = nxt.line_count;
        res.window_line = nxt.win_line_count;
    end

endmodule

`default_nettype wire

// ===== design/lcd_mode_timing_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// lcd_mode_timing_sequencer_unit: lcd mode and scanline timing sequencer
// tracks oam scan / draw / hblank / vblank from elapsed cycle reports
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries one step word: elapsed
//   machine cycles plus the live lcd control, stat enable and window bits.
//   output channel (out_valid / out_stall) returns one result word per step:
//   mode, line, window line and the event pulses for that step.
//   a word accepted into the input register passes through the step logic
//   into the result register, where it waits until the receiver takes it.
//   throughput: one word per clock while out_stall is low; the state update
//   is a single compare, add and subtract on the 11-bit mode clock, done combinationally.
//   reset: mode clock, mode (hblank), line, window line, window activity and
//   the lcd-on history all clear; both valid flags drop.
//   receiver stall: the result register holds; the input register still
//   takes one more word, then in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_mode_timing_sequencer_unit (
    input  wire        clk,
    input  wire        rst_n,
    // step word in
    input  wire        in_valid,
    output logic       in_stall,
    input  wire [7:0]  cycles,
    input  wire        lcd_on,
    input  wire        bg_win_on,
    input  wire        window_on,
    input  wire [7:0]  window_y,
    input  wire [7:0]  window_x,
    input  wire        hblank_irq_en,
    input  wire        vblank_irq_en,
    input  wire        oam_irq_en,
    // result word out
    output logic       out_valid,
    input  wire        out_stall,
    output logic [1:0] mode,
    output logic [7:0] line,
    output logic [7:0] window_line,
    output logic       render_line,
    output logic       vblank_irq,
    output logic       stat_irq,
    output logic       lyc_check,
    output logic       frame_ready,
    output logic       screen_clear
);
    import lmts_pkg::*;

    // input register
    lmts_word_t   word_reg;
    logic         in_valid_reg;

    // sequencer state
    lmts_state_t  state_reg;
    lmts_state_t  state_next;

    // result register
    lmts_result_t res_reg;
    lmts_result_t res_next;
    logic         out_valid_reg;

    logic         advance;
    logic         in_take;

    // a step retires when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            word_reg.cycles        <= cycles;
            word_reg.lcd_on        <= lcd_on;
            word_reg.bg_win_on     <= bg_win_on;
            word_reg.window_on     <= window_on;
            word_reg.window_y      <= window_y;
            word_reg.window_x      <= window_x;
            word_reg.hblank_irq_en <= hblank_irq_en;
            word_reg.vblank_irq_en <= vblank_irq_en;
            word_reg.oam_irq_en    <= oam_irq_en;
        end
    end

    lmts_step u_step (
        .word (word_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // state only moves when the step is committed to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.dot_count      <= '0;
            state_reg.cur_mode       <= MODE_HBLANK;
            state_reg.line_count     <= '0;
            state_reg.win_line_count <= '0;
            state_reg.win_active     <= 1'b0;
            state_reg.lcd_was_on     <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid    = out_valid_reg;
    assign mode         = res_reg.mode;
    assign line         = res_reg.line;
    assign window_line  = res_reg.window_line;
    assign render_line  = res_reg.render_line;
    assign vblank_irq   = res_reg.vblank_irq;
    assign stat_irq     = res_reg.stat_irq;
    assign lyc_check    = res_reg.lyc_check;
    assign frame_ready  = res_reg.frame_ready;
    assign screen_clear = res_reg.screen_clear;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // a finished draw always lands in hblank
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.render_line |-> res_reg.mode == MODE_HBLANK)
    else $error("render_line without hblank");

    // frame completion coincides with vblank entry on the first vblank line
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.frame_ready |->
            res_reg.vblank_irq && res_reg.mode == MODE_VBLANK
            && res_reg.line == VISIBLE_LINES)
    else $error("frame_ready without vblank entry");

    // switching off and switching on cannot happen in one step
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.screen_clear && res_reg.lyc_check))
    else $error("screen_clear and lyc_check together");

    // while the lcd is off the sequencer stays fully cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.lcd_was_on |->
            state_reg.cur_mode == MODE_HBLANK && state_reg.line_count == 8'd0
            && state_reg.dot_count == '0 && !state_reg.win_active)
    else $error("state not cleared while lcd off");

    // state advances only when a step retires
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
    else $error("state changed without a step");

endmodule

`default_nettype wire
